[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/tbc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbc_pkg
// Shared types, register codes and box merge helpers.
// ---------------------------------------------------------------------------
package tbc_pkg;

	localparam int COORD_W = 32;
	localparam int LIMIT_W = 31;
	localparam int CNT_W   = 16;
	localparam int BOX_W   = 6 * COORD_W;
	localparam int ENT_W   = BOX_W + CNT_W;

	localparam logic [LIMIT_W-1:0] CLUSTER_LIMIT_RST = 31'd5120000;
	localparam logic [LIMIT_W-1:0] SUB_LIMIT_RST     = 31'd128000;

	typedef enum logic [0:0] {
		REG_CLUSTER_LIMIT = 1'b0,
		REG_SUB_LIMIT     = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CSRCH,
		S_CPOST,
		S_SSRCH,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] hi;
		logic [2:0][COORD_W-1:0] lo;
	} box_t;

	typedef struct packed {
		logic fits;
		box_t box;
	} merge_t;

	typedef struct packed {
		logic in_use;
		logic open;
		logic clr;
		logic sub_inc;
	} cell_ctrl_t;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		bump = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
	endfunction

	// merged box of entry and face; fits when every extent is within limit
	function automatic merge_t merge_box(input box_t ent, input box_t fb,
			input logic [LIMIT_W-1:0] limit);
		merge_t m;
		logic [COORD_W:0] ext;
		m.fits = 1'b1;
		for (int a = 0; a < 3; a++) begin
			m.box.lo[a] = ($signed(ent.lo[a]) < $signed(fb.lo[a])) ? ent.lo[a] : fb.lo[a];
			m.box.hi[a] = ($signed(ent.hi[a]) > $signed(fb.hi[a])) ? ent.hi[a] : fb.hi[a];
			ext = {m.box.hi[a][COORD_W-1], m.box.hi[a]} - {m.box.lo[a][COORD_W-1], m.box.lo[a]};
			if (ext > {2'b00, limit}) begin
				m.fits = 1'b0;
			end
		end
		return m;
	endfunction

endpackage

[rtl/core/tbc_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbc_if
// Request channels: triangle in, assignment result out.
// ---------------------------------------------------------------------------
interface tbc_face_if;
	logic        valid;
	logic        ready;
	logic        first_face;
	logic signed [31:0] v0_x;
	logic signed [31:0] v0_y;
	logic signed [31:0] v0_z;
	logic signed [31:0] v1_x;
	logic signed [31:0] v1_y;
	logic signed [31:0] v1_z;
	logic signed [31:0] v2_x;
	logic signed [31:0] v2_y;
	logic signed [31:0] v2_z;

	modport source (output valid, first_face, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
		v2_x, v2_y, v2_z, input ready);
	modport sink (input valid, first_face, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
		v2_x, v2_y, v2_z, output ready);
endinterface

interface tbc_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  cluster_index;
	logic [3:0]  subcluster_index;
	logic        new_cluster;
	logic        new_subcluster;
	logic [15:0] cluster_faces;
	logic [15:0] subcluster_faces;
	logic        overflow;

	modport source (output valid, cluster_index, subcluster_index, new_cluster,
		new_subcluster, cluster_faces, subcluster_faces, overflow, input ready);
	modport sink (input valid, cluster_index, subcluster_index, new_cluster,
		new_subcluster, cluster_faces, subcluster_faces, overflow, output ready);
endinterface

[rtl/core/tbc_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbc_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module tbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/tbc_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbc_cell
// One cluster slot: box, face count, subcluster fill; tests the passing token.
// ---------------------------------------------------------------------------
module tbc_cell #(
	parameter int SNW = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tok_in,
	output logic                          tok_out,
	input  tbc_pkg::cell_ctrl_t           ctrl,
	input  tbc_pkg::box_t                 fbox,
	input  logic [tbc_pkg::LIMIT_W-1:0]   limit,
	output logic                          hit,
	output logic [tbc_pkg::CNT_W-1:0]     count,
	output logic [SNW-1:0]                sub_used
);

	tbc_pkg::box_t                 box_q;
	logic [tbc_pkg::CNT_W-1:0]     count_q;
	logic [SNW-1:0]                sub_used_q;
	logic                          tok_q;
	tbc_pkg::merge_t               m;

	assign m       = tbc_pkg::merge_box(box_q, fbox, limit);
	assign hit     = tok_in & ctrl.in_use & m.fits;
	assign tok_out = tok_q;
	assign count   = count_q;
	assign sub_used = sub_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q      <= 1'b0;
			sub_used_q <= '0;
		end else begin
			tok_q <= tok_in & ~hit;
			if (ctrl.clr || ctrl.open) begin
				sub_used_q <= '0;
			end else if (ctrl.sub_inc) begin
				sub_used_q <= sub_used_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.open) begin
			box_q   <= fbox;
			count_q <= tbc_pkg::CNT_W'(1);
		end else if (hit) begin
			box_q   <= m.box;
			count_q <= tbc_pkg::bump(count_q);
		end
	end

endmodule

[rtl/core/triangle_box_clusterer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// triangle_box_clusterer
// First-fit clustering of triangles by bounding box, two levels deep.
// ---------------------------------------------------------------------------
// One triangle is handled at a time. Its bounding box is formed on accept;
// a token then walks a row of MAX_CLUSTERS cluster cells, one cell per
// cycle, and the first used cell whose merged box stays within the
// cluster limit on every axis takes it. If none does, a new cluster is
// opened (or overflow is flagged when all are in use). The cluster's
// subclusters live in a RAM and are read one per cycle through its
// registered read port, first fit again, with the subcluster limit.
// Time per triangle grows with MAX_CLUSTERS and the subclusters in use;
// the cell chain and the single RAM read port set it. A new request is
// taken only after the previous result is loaded into the output
// register. Limits must be written through cfg_* only while the block is
// idle, which the block does not enforce. first_face empties all tables.
// ---------------------------------------------------------------------------
module triangle_box_clusterer #(
	parameter int MAX_CLUSTERS    = 16,
	parameter int MAX_SUBCLUSTERS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [tbc_pkg::LIMIT_W-1:0] cfg_wdata,
	tbc_face_if.sink                    face,
	tbc_result_if.source                result
);

	localparam int CIW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int CNW = $clog2(MAX_CLUSTERS + 1);
	localparam int SIW = (MAX_SUBCLUSTERS > 1) ? $clog2(MAX_SUBCLUSTERS) : 1;
	localparam int SNW = $clog2(MAX_SUBCLUSTERS + 1);
	localparam int RD  = MAX_CLUSTERS * (2 ** SIW);
	localparam int AW  = CIW + SIW;
	localparam int CW  = tbc_pkg::CNT_W;

	// limits
	logic [tbc_pkg::LIMIT_W-1:0] climit_q, slimit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			climit_q <= tbc_pkg::CLUSTER_LIMIT_RST;
			slimit_q <= tbc_pkg::SUB_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (tbc_pkg::reg_idx_t'(cfg_index))
				tbc_pkg::REG_CLUSTER_LIMIT: climit_q <= cfg_wdata;
				tbc_pkg::REG_SUB_LIMIT:     slimit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// face box on accept
	tbc_pkg::box_t fbox_d, fbox_q;
	logic signed [31:0] vx [3][3];

	always_comb begin
		vx[0][0] = face.v0_x; vx[0][1] = face.v0_y; vx[0][2] = face.v0_z;
		vx[1][0] = face.v1_x; vx[1][1] = face.v1_y; vx[1][2] = face.v1_z;
		vx[2][0] = face.v2_x; vx[2][1] = face.v2_y; vx[2][2] = face.v2_z;
		for (int a = 0; a < 3; a++) begin
			fbox_d.lo[a] = vx[0][a];
			fbox_d.hi[a] = vx[0][a];
			for (int v = 1; v < 3; v++) begin
				if (vx[v][a] < $signed(fbox_d.lo[a])) fbox_d.lo[a] = vx[v][a];
				if (vx[v][a] > $signed(fbox_d.hi[a])) fbox_d.hi[a] = vx[v][a];
			end
		end
	end

	// control state
	tbc_pkg::state_t state_q, state_d;
	logic            accept;
	logic [CNW-1:0]  used_q;
	logic            start_q;
	logic [CIW-1:0]  ci_q;
	logic            newc_q;
	logic [SNW-1:0]  su_q, rs_q;
	logic [SIW-1:0]  tag_s1;
	logic            vld_s1;
	logic            out_valid_q;

	// cell row
	logic [MAX_CLUSTERS:0]      tok;
	logic [MAX_CLUSTERS-1:0]    hit;
	logic [CW-1:0]              count_arr [MAX_CLUSTERS];
	logic [SNW-1:0]             sub_used_arr [MAX_CLUSTERS];
	tbc_pkg::cell_ctrl_t        ctrl [MAX_CLUSTERS];
	logic [CIW-1:0]             hit_idx;

	// strobes from the FSM
	logic c_open, c_ovf, s_rd, s_fit, s_miss, s_full, out_load;

	// subcluster RAM
	logic [AW-1:0]             raddr, waddr;
	logic                      we;
	logic [tbc_pkg::ENT_W-1:0] wdata, rdata;
	tbc_pkg::box_t             rd_box;
	logic [CW-1:0]             rd_cnt;
	tbc_pkg::merge_t           sm;

	assign tok[0] = start_q;

	for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
		always_comb begin
			ctrl[i].in_use  = CNW'(i) < used_q;
			ctrl[i].open    = c_open && (CNW'(i) == used_q);
			ctrl[i].clr     = accept && face.first_face;
			ctrl[i].sub_inc = s_miss && !s_full && (CIW'(i) == ci_q);
		end

		tbc_cell #(.SNW(SNW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1]),
			.ctrl     (ctrl[i]),
			.fbox     (fbox_q),
			.limit    (climit_q),
			.hit      (hit[i]),
			.count    (count_arr[i]),
			.sub_used (sub_used_arr[i])
		);
	end

	// token dies at its hit, so at most one bit of hit is set
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < MAX_CLUSTERS; i++) begin
			if (hit[i]) hit_idx = hit_idx | CIW'(i);
		end
	end

	assign rd_box = rdata[tbc_pkg::ENT_W-1:CW];
	assign rd_cnt = rdata[CW-1:0];
	assign sm     = tbc_pkg::merge_box(rd_box, fbox_q, slimit_q);
	assign raddr  = {ci_q, rs_q[SIW-1:0]};
	assign s_full = su_q == SNW'(MAX_SUBCLUSTERS);

	always_comb begin
		if (s_fit) begin
			waddr = {ci_q, tag_s1};
			wdata = {sm.box, tbc_pkg::bump(rd_cnt)};
		end else begin
			waddr = {ci_q, su_q[SIW-1:0]};
			wdata = {fbox_q, CW'(1)};
		end
	end
	assign we = s_fit || (s_miss && !s_full);

	tbc_ram #(.WIDTH(tbc_pkg::ENT_W), .DEPTH(RD)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (s_rd),
		.raddr (raddr),
		.rdata (rdata)
	);

	// FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		face.ready = 1'b0;
		c_open     = 1'b0;
		c_ovf      = 1'b0;
		s_rd       = 1'b0;
		s_fit      = 1'b0;
		s_miss     = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			tbc_pkg::S_IDLE: begin
				face.ready = 1'b1;
				if (face.valid) state_d = tbc_pkg::S_CSRCH;
			end
			tbc_pkg::S_CSRCH: begin
				if (|hit) begin
					state_d = tbc_pkg::S_CPOST;
				end else if (tok[MAX_CLUSTERS]) begin
					if (used_q == CNW'(MAX_CLUSTERS)) begin
						c_ovf   = 1'b1;
						state_d = tbc_pkg::S_OUT;
					end else begin
						c_open  = 1'b1;
						state_d = tbc_pkg::S_CPOST;
					end
				end
			end
			tbc_pkg::S_CPOST: state_d = tbc_pkg::S_SSRCH;
			tbc_pkg::S_SSRCH: begin
				s_fit  = vld_s1 && sm.fits;
				s_miss = vld_s1 ? (!sm.fits && (SNW'(tag_s1) + SNW'(1)) == su_q)
					: (su_q == '0);
				if (s_fit || s_miss) state_d = tbc_pkg::S_OUT;
				else s_rd = rs_q < su_q;
			end
			tbc_pkg::S_OUT: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = tbc_pkg::S_IDLE;
				end
			end
			default: state_d = tbc_pkg::S_IDLE;
		endcase
	end

	assign accept = face.valid && face.ready;

	// result being built
	logic [3:0]    r_ci, r_si;
	logic          r_newc, r_news, r_ovf;
	logic [CW-1:0] r_cf, r_sf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			start_q <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			start_q <= accept;
			if (accept && face.first_face) used_q <= '0;
			else if (c_open) used_q <= used_q + 1'b1;
			if (state_q == tbc_pkg::S_CPOST) vld_s1 <= 1'b0;
			else vld_s1 <= s_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) fbox_q <= fbox_d;
		if (state_q == tbc_pkg::S_CSRCH) begin
			ci_q   <= c_open ? used_q[CIW-1:0] : hit_idx;
			newc_q <= c_open;
		end
		if (c_ovf) begin
			r_ci <= '0; r_si <= '0; r_newc <= 1'b0; r_news <= 1'b0;
			r_cf <= '0; r_sf <= '0; r_ovf <= 1'b1;
		end
		if (state_q == tbc_pkg::S_CPOST) begin
			r_ci   <= 4'(ci_q);
			r_newc <= newc_q;
			r_cf   <= count_arr[ci_q];
			su_q   <= sub_used_arr[ci_q];
			rs_q   <= '0;
		end
		if (s_rd) begin
			tag_s1 <= rs_q[SIW-1:0];
			rs_q   <= rs_q + 1'b1;
		end
		if (s_fit) begin
			r_si <= 4'(tag_s1); r_sf <= tbc_pkg::bump(rd_cnt);
			r_news <= 1'b0; r_ovf <= 1'b0;
		end else if (s_miss) begin
			r_si   <= s_full ? 4'd0 : 4'(su_q);
			r_sf   <= s_full ? '0 : CW'(1);
			r_news <= !s_full;
			r_ovf  <= s_full;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result.cluster_index    <= r_ci;
			result.subcluster_index <= r_si;
			result.new_cluster      <= r_newc;
			result.new_subcluster   <= r_news;
			result.cluster_faces    <= r_cf;
			result.subcluster_faces <= r_sf;
			result.overflow         <= r_ovf;
		end
	end

	assign result.valid = out_valid_q;

endmodule

[rtl/core/tbc_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbc_checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        r_valid,
	input logic        r_ready,
	input logic [3:0]  r_ci,
	input logic        r_newc,
	input logic        r_news,
	input logic [15:0] r_cf,
	input logic [15:0] r_sf,
	input logic        r_ovf
);

	`ASSERT_NEXT(a_valid_hold, clk, arst_n, r_valid && !r_ready, r_valid)
	`ASSERT_NEXT(a_ci_hold, clk, arst_n, r_valid && !r_ready, $stable(r_ci))
	`ASSERT_IMPL(a_newc_first, clk, arst_n, r_valid && r_newc, r_cf == 16'd1 && r_news)
	`ASSERT_IMPL(a_newc_room, clk, arst_n, r_valid && r_newc, !r_ovf)
	`ASSERT_IMPL(a_news_first, clk, arst_n, r_valid && r_news, r_sf == 16'd1 && !r_ovf)

endmodule

bind triangle_box_clusterer tbc_checker u_tbc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_ci    (result.cluster_index),
	.r_newc  (result.new_cluster),
	.r_news  (result.new_subcluster),
	.r_cf    (result.cluster_faces),
	.r_sf    (result.subcluster_faces),
	.r_ovf   (result.overflow)
);

[tb/triangle_box_clusterer_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// triangle_box_clusterer_tb
// Self-checking bench for the two-level triangle box clusterer.
// ---------------------------------------------------------------------------
// Triangles are sent on the face channel and results are taken from the
// result channel. Both sides stall at random per request. A
// behavioral model of the cluster tables predicts every result, and results
// are compared in order, field by field. A directed table runs first, then
// random phases under several limit settings, the extremes among them.
// ---------------------------------------------------------------------------
module triangle_box_clusterer_tb;

	localparam int NCL = 16;
	localparam int NSC = 16;

	typedef struct packed {
		logic [3:0]  cl;
		logic [3:0]  sc;
		logic        ncl;
		logic        nsc;
		logic [15:0] cf;
		logic [15:0] sf;
		logic        ovf;
	} assign_t;

	typedef struct {
		logic        ff;
		logic [31:0] v[9];
		logic        chk;
		assign_t     res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = tbc_pkg::REG_CLUSTER_LIMIT;
	logic [tbc_pkg::LIMIT_W-1:0] cfg_wdata = '0;

	tbc_face_if   face();
	tbc_result_if result();

	triangle_box_clusterer u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .face(face.sink), .result(result.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model state; bounds are lo x,y,z then hi x,y,z
	logic [tbc_pkg::LIMIT_W-1:0] cl_limit, sc_limit;
	int unsigned        n_cl;
	logic signed [31:0] cl_box[NCL][6];
	logic [15:0]        cl_cnt[NCL];
	int unsigned        n_sc[NCL];
	logic signed [31:0] sc_box[NCL][NSC][6];
	logic [15:0]        sc_cnt[NCL][NSC];

	assign_t pending_assign[$];
	int      errors = 0;
	int      sent = 0;

	// merge face box into entry when every merged extent fits the limit
	function automatic logic fits_merge(ref logic signed [31:0] b[6],
			input logic signed [31:0] f[6], input logic [tbc_pkg::LIMIT_W-1:0] lim);
		logic signed [31:0] nb[6];
		longint ext;
		for (int a = 0; a < 3; a++) begin
			nb[a] = (b[a] < f[a]) ? b[a] : f[a];
			nb[a+3] = (b[a+3] > f[a+3]) ? b[a+3] : f[a+3];
			ext = longint'(nb[a+3]) - longint'(nb[a]);
			if (ext > longint'(lim))
				return 1'b0;
		end
		for (int a = 0; a < 6; a++)
			b[a] = nb[a];
		return 1'b1;
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] c);
		return (c == 16'hFFFF) ? c : c + 16'd1;
	endfunction

	function automatic assign_t predict_assign(input logic ff, input logic [31:0] v[9]);
		assign_t r;
		logic signed [31:0] f[6];
		int ci, si;
		logic hit;
		r = '0;
		if (ff) begin
			n_cl = 0;
			for (int i = 0; i < NCL; i++)
				n_sc[i] = 0;
		end
		for (int a = 0; a < 3; a++) begin
			f[a] = v[a];
			f[a+3] = v[a];
			for (int k = 1; k < 3; k++) begin
				if ($signed(v[3*k+a]) < f[a]) f[a] = v[3*k+a];
				if ($signed(v[3*k+a]) > f[a+3]) f[a+3] = v[3*k+a];
			end
		end
		hit = 1'b0;
		for (ci = 0; ci < n_cl; ci++) begin
			if (fits_merge(cl_box[ci], f, cl_limit)) begin
				hit = 1'b1;
				break;
			end
		end
		if (!hit) begin
			if (n_cl >= NCL) begin
				r.ovf = 1'b1;
				return r;
			end
			ci = n_cl++;
			cl_box[ci] = f;
			cl_cnt[ci] = 0;
			n_sc[ci] = 0;
			r.ncl = 1'b1;
		end
		cl_cnt[ci] = sat_inc(cl_cnt[ci]);
		r.cl = ci[3:0];
		r.cf = cl_cnt[ci];
		hit = 1'b0;
		for (si = 0; si < n_sc[ci]; si++) begin
			if (fits_merge(sc_box[ci][si], f, sc_limit)) begin
				hit = 1'b1;
				break;
			end
		end
		if (!hit) begin
			if (n_sc[ci] >= NSC) begin
				r.ovf = 1'b1;
				return r;
			end
			si = n_sc[ci]++;
			sc_box[ci][si] = f;
			sc_cnt[ci][si] = 0;
			r.nsc = 1'b1;
		end
		sc_cnt[ci][si] = sat_inc(sc_cnt[ci][si]);
		r.sc = si[3:0];
		r.sf = sc_cnt[ci][si];
		return r;
	endfunction

	task automatic write_limit(input tbc_pkg::reg_idx_t idx,
			input logic [tbc_pkg::LIMIT_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tbc_pkg::REG_CLUSTER_LIMIT) cl_limit = val;
		else sc_limit = val;
	endtask

	// block is idle once every result is back plus its latency
	task automatic drain;
		face.valid <= 1'b0;
		while (pending_assign.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	// valid stays up after accept when the next request follows with no gap;
	// drain drops it after the last one
	task automatic send_face(input logic ff, input logic [31:0] v[9],
			input logic chk = 1'b0, input assign_t typed = '0);
		int idle;
		assign_t pred;
		idle = $urandom_range(0, 7);
		if (idle != 0) begin
			face.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		face.valid <= 1'b1;
		face.first_face <= ff;
		face.v0_x <= v[0]; face.v0_y <= v[1]; face.v0_z <= v[2];
		face.v1_x <= v[3]; face.v1_y <= v[4]; face.v1_z <= v[5];
		face.v2_x <= v[6]; face.v2_y <= v[7]; face.v2_z <= v[8];
		@(posedge clk);
		while (!face.ready)
			@(posedge clk);
		// accepted at this edge; predict in acceptance order
		pred = predict_assign(ff, v);
		pending_assign = {pending_assign, chk ? typed : pred};
		sent++;
	endtask

	// random coordinate: mostly local around a center, sometimes any value
	function automatic logic [31:0] rand_coord(input int center, input int spread);
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return center + $signed($urandom_range(0, 2 * spread)) - spread;
		endcase
	endfunction

	// receiver: random stall per request, in-order field compare
	initial begin
		assign_t got, exp;
		int idle_n;
		result.ready = 1'b0;
		idle_n = $urandom_range(0, 7);
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (result.valid && result.ready) begin
				got = '{result.cluster_index, result.subcluster_index,
					result.new_cluster, result.new_subcluster,
					result.cluster_faces, result.subcluster_faces, result.overflow};
				if (pending_assign.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h", got);
				end else begin
					exp = pending_assign.pop_front();
					if (got !== exp) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch: exp cl %0d sc %0d ncl %b nsc %b cf %0d",
								" sf %0d ovf %b / got cl %0d sc %0d ncl %b nsc %b",
								" cf %0d sf %0d ovf %b"},
								exp.cl, exp.sc, exp.ncl, exp.nsc, exp.cf, exp.sf, exp.ovf,
								got.cl, got.sc, got.ncl, got.nsc, got.cf, got.sf, got.ovf);
					end
				end
				idle_n = $urandom_range(0, 7);
				result.ready <= (idle_n == 0);
			end else if (!result.ready) begin
				if (idle_n != 0) idle_n--;
				if (idle_n == 0) result.ready <= 1'b1;
			end
		end
	end

	// timeout
	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		row_t tbl[$];
		row_t r;
		logic [31:0] v[9];
		int c[3];
		int spread;
		logic [tbc_pkg::LIMIT_W-1:0] lims[5][2];

		face.valid = 1'b0;
		face.first_face = 1'b0;
		face.v0_x = '0; face.v0_y = '0; face.v0_z = '0;
		face.v1_x = '0; face.v1_y = '0; face.v1_z = '0;
		face.v2_x = '0; face.v2_y = '0; face.v2_z = '0;
		cl_limit = tbc_pkg::CLUSTER_LIMIT_RST;
		sc_limit = tbc_pkg::SUB_LIMIT_RST;
		n_cl = 0;
		for (int i = 0; i < NCL; i++)
			n_sc[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (40) @(posedge clk);

		// directed rows: first rows after reset have obvious results
		r.ff = 1'b1; r.v = '{default: 32'd0}; r.chk = 1'b1;
		r.res = '{4'd0, 4'd0, 1'b1, 1'b1, 16'd1, 16'd1, 1'b0};
		tbl = {tbl, r};
		r.ff = 1'b0; r.res = '{4'd0, 4'd0, 1'b0, 1'b0, 16'd2, 16'd2, 1'b0};
		tbl = {tbl, r};
		// full-range triangle: opens cluster 1, oversized
		r.v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h0, 32'h0, 32'h0};
		r.res = '{4'd1, 4'd0, 1'b1, 1'b1, 16'd1, 16'd1, 1'b0};
		tbl = {tbl, r};
		// same again: oversized entry takes nothing, new cluster 2
		r.res = '{4'd2, 4'd0, 1'b1, 1'b1, 16'd1, 16'd1, 1'b0};
		tbl = {tbl, r};
		// just within subcluster limit of origin cluster, then just outside
		r.chk = 1'b0;
		r.v = '{32'd0, 32'd0, 32'd0, 32'd128000, 32'd0, 32'd0, 32'd5, 32'd5, 32'd5};
		tbl = {tbl, r};
		r.v = '{32'd0, 32'd0, 32'd0, 32'd128001, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
		tbl = {tbl, r};
		r.v = '{-32'sd7, -32'sd9, 32'd3, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6};
		tbl = {tbl, r};
		foreach (tbl[i])
			send_face(tbl[i].ff, tbl[i].v, tbl[i].chk, tbl[i].res);
		drain();

		// fill cluster table to overflow, then subcluster table of one cluster
		for (int i = 0; i < 18; i++) begin
			for (int k = 0; k < 9; k++)
				v[k] = 32'd40000000 * (i + 1);
			send_face(i == 0, v);
		end
		for (int i = 0; i < 18; i++) begin
			for (int k = 0; k < 9; k++)
				v[k] = 32'd200000 * i;
			send_face(i == 0, v);
		end
		drain();

		// limit settings: reset, extremes, and in between
		lims = '{'{tbc_pkg::CLUSTER_LIMIT_RST, tbc_pkg::SUB_LIMIT_RST}, '{31'd0, 31'd0},
			'{31'h7FFFFFFF, 31'h7FFFFFFF}, '{31'd2000000, 31'd60000},
			'{31'h7FFFFFFF, 31'd0}};
		for (int p = 0; p < 5; p++) begin
			write_limit(tbc_pkg::REG_CLUSTER_LIMIT, lims[p][0]);
			write_limit(tbc_pkg::REG_SUB_LIMIT, lims[p][1]);
			for (int n = 0; n < 360; n++) begin
				// mostly meshes of nearby triangles, restart now and then
				if (n % 60 == 0 || $urandom_range(0, 40) == 0)
					for (int a = 0; a < 3; a++)
						c[a] = $urandom_range(0, 4) == 0 ? $urandom() :
							$signed($urandom_range(0, 16000000)) - 8000000;
				spread = $urandom_range(0, 3) == 0 ? 3000000 : 60000;
				for (int k = 0; k < 9; k++)
					v[k] = rand_coord(c[k % 3], spread);
				send_face(n % 60 == 0 || $urandom_range(0, 100) == 0, v);
			end
			drain();
		end

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
